// ===== design/itsd_pkg.sv =====
`default_nettype none

package itsd_pkg;

  // Header layout
  localparam int unsigned HdrSize    = 1040;
  localparam int unsigned VersionOk  = 2;
  localparam int unsigned WidthBase  = 36;
  localparam int unsigned HeightBase = 100;
  localparam int unsigned OffsetBase = 164;
  localparam int unsigned PalBase    = 260;
  localparam int unsigned PalBytes   = 768;
  localparam int unsigned PalEntries = 256;
  localparam int unsigned ClearIndex = 255;

  localparam int unsigned PosW   = 32;
  localparam int unsigned HdrPosW = 11;
  localparam int unsigned CoordW = 14;
  localparam int unsigned MipW   = 4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_VERSION = 3'd2,
    ST_DIMS    = 3'd3,
    ST_OFFSET  = 3'd4,
    ST_TRUNC   = 3'd5
  } status_t;

endpackage

`default_nettype wire

// ===== design/indexed_texture_stream_decoder.sv =====
`default_nettype none

// Palette-indexed texture decoder.
// Input: one byte of the texture file per in_ transaction; in_last_byte marks the
// final byte of a file, and the next byte starts a new file at header position 0.
// Output: zero or one out_ transaction per input byte: a pixel (RGBA, column, row)
// and/or a status report. Errors are reported once; the rest of the file is dropped.
// Config: a cfg_ transaction writes the mip level select (cfg_level); cfg_ready is
// always high. Write it only while no bytes are in flight.
// Throughput: one byte per cycle while the output is not stalled. The palette lives in three 256x8
// RAMs (red, green, blue) so one pixel reads all three in the same cycle.
// Path: each result is registered in the pending stage, alongside the palette RAM
// read, and then in the output register.
// Stall: when out_ready is low the output register holds; the stage behind it
// holds one more result, and in_ready drops only while that stage is full.
// Bytes that produce no result still flow when the stage is empty.
// Reset (rst_n low, synchronous): header phase, position 0, level select 0, output
// empty. Palette contents are not cleared: every entry is written by the header
// before any pixel can read it, so there is no clearing pass and no RAW hazard.
module indexed_texture_stream_decoder #(
  parameter int MAX_DIM = 16384
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [itsd_pkg::MipW-1:0]     cfg_level,
  // byte stream in
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_last_byte,
  // pixel / status out
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_alpha,
  output logic [itsd_pkg::CoordW-1:0]        out_pixel_x,
  output logic [itsd_pkg::CoordW-1:0]        out_pixel_y,
  output logic                               out_has_pixel,
  output logic [2:0]                         out_status,
  output logic                               out_image_done
);

  import itsd_pkg::*;

  localparam logic [PosW-1:0]    MaxDimW    = PosW'(MAX_DIM);
  localparam logic [HdrPosW-1:0] HdrLastPos = HdrPosW'(HdrSize - 1);
  localparam logic [HdrPosW-1:0] WidthPos   = HdrPosW'(WidthBase);
  localparam logic [HdrPosW-1:0] HeightPos  = HdrPosW'(HeightBase);
  localparam logic [HdrPosW-1:0] OffsetPos  = HdrPosW'(OffsetBase);
  localparam logic [HdrPosW-1:0] PalFirst   = HdrPosW'(PalBase);
  localparam logic [HdrPosW-1:0] PalLast    = HdrPosW'(PalBase + PalBytes - 1);
  localparam logic [PosW-1:0]    HdrSizeW   = PosW'(HdrSize);
  localparam logic [PosW-1:0]    VersionW   = PosW'(VersionOk);
  localparam logic [7:0]         ClearIdx   = 8'(ClearIndex);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  phase_t              phase_r, phase_nxt;
  logic [MipW-1:0]     mip_r;
  logic [PosW-1:0]     pos_r, pos_nxt;
  logic [PosW-1:0]     version_r, version_nxt;
  logic [PosW-1:0]     width_r, width_nxt;
  logic [PosW-1:0]     height_r, height_nxt;
  logic [PosW-1:0]     offset_r, offset_nxt;
  logic [CoordW-1:0]   col_r, col_nxt;
  logic [CoordW-1:0]   row_r, row_nxt;
  logic [7:0]          pal_idx_r, pal_idx_nxt;
  logic [1:0]          pal_comp_r, pal_comp_nxt;

  // result stage (waiting on palette read)
  logic                s1_valid_r;
  logic                s1_pix_r;
  logic                s1_clear_r;
  logic [CoordW-1:0]   s1_x_r, s1_y_r;
  status_t             s1_status_r;
  logic                s1_done_r;

  // output register
  logic                out_valid_r;
  logic [7:0]          out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic [CoordW-1:0]   out_x_r, out_y_r;
  logic                out_pix_r;
  status_t             out_status_r;
  logic                out_done_r;

  // ---------------------------------------------------------------------------
  // Decode of the current byte
  // ---------------------------------------------------------------------------
  logic                accept;
  logic                advance;
  logic [HdrPosW-1:0]  hpos;
  logic                hdr_end;
  logic                ver_bad, dim_bad, off_bad;
  logic                in_gap;
  logic [CoordW:0]     col_inc, row_inc;
  logic                col_wrap, final_px;
  logic [HdrPosW-1:0]  w_rel, h_rel, o_rel;
  logic                w_sel, h_sel, o_sel, v_sel, p_sel;
  logic [4:0]          lane_sh;

  logic                res_valid;
  logic                res_pix;
  status_t             res_status;
  logic                res_done;
  logic                pal_we;
  logic [7:0]          ram_r, ram_g, ram_b;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign hpos    = pos_r[HdrPosW-1:0];
  assign hdr_end = (hpos == HdrLastPos);
  assign ver_bad = (version_r != VersionW);
  assign dim_bad = (width_r == '0) || (height_r == '0) ||
                   (width_r > MaxDimW) || (height_r > MaxDimW);
  assign off_bad = (offset_r < HdrSizeW);
  assign in_gap  = (pos_r < offset_r);

  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign col_wrap = (PosW'(col_inc) >= width_r);
  assign final_px = col_wrap && (PosW'(row_inc) >= height_r);

  // Field words for the selected mip level sit at base + 4*level; all bases are
  // multiples of four, so the byte lane is just the low two position bits.
  assign w_rel   = hpos - WidthPos;
  assign h_rel   = hpos - HeightPos;
  assign o_rel   = hpos - OffsetPos;
  assign w_sel   = (hpos >= WidthPos)  && (w_rel[HdrPosW-1:2] == (HdrPosW-2)'(mip_r));
  assign h_sel   = (hpos >= HeightPos) && (h_rel[HdrPosW-1:2] == (HdrPosW-2)'(mip_r));
  assign o_sel   = (hpos >= OffsetPos) && (o_rel[HdrPosW-1:2] == (HdrPosW-2)'(mip_r));
  assign v_sel   = (hpos < HdrPosW'(4));
  assign p_sel   = (hpos >= PalFirst) && (hpos <= PalLast);
  assign lane_sh = {hpos[1:0], 3'b000};

  // ---------------------------------------------------------------------------
  // Next phase
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (!hdr_end) begin
            if (in_last_byte) phase_nxt = PH_IDLE;
          end else if (ver_bad || dim_bad || off_bad || in_last_byte) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (in_gap) begin
            if (in_last_byte) phase_nxt = PH_IDLE;
          end else if (final_px || in_last_byte) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_IDLE: phase_nxt = PH_IDLE;
        default: phase_nxt = PH_HEADER;
      endcase
      // end of file always rearms for the next one
      if (in_last_byte) phase_nxt = PH_HEADER;
    end
  end

  // ---------------------------------------------------------------------------
  // Result and datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    res_valid    = 1'b0;
    res_pix      = 1'b0;
    res_status   = ST_OK;
    res_done     = 1'b0;
    pos_nxt      = pos_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    version_nxt  = version_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    offset_nxt   = offset_r;
    pal_idx_nxt  = pal_idx_r;
    pal_comp_nxt = pal_comp_r;
    pal_we       = 1'b0;

    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (v_sel) version_nxt[lane_sh +: 8] = in_data_byte;
          if (w_sel) width_nxt[lane_sh +: 8]   = in_data_byte;
          if (h_sel) height_nxt[lane_sh +: 8]  = in_data_byte;
          if (o_sel) offset_nxt[lane_sh +: 8]  = in_data_byte;
          if (p_sel) begin
            pal_we = 1'b1;
            if (pal_comp_r == 2'd2) begin
              pal_comp_nxt = 2'd0;
              pal_idx_nxt  = pal_idx_r + 1'b1;
            end else begin
              pal_comp_nxt = pal_comp_r + 1'b1;
            end
          end
          if (!hdr_end) begin
            if (in_last_byte) begin
              res_valid  = 1'b1;
              res_status = ST_SHORT;
              res_done   = 1'b1;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end else begin
            priority if (ver_bad) begin
              res_valid  = 1'b1;
              res_status = ST_VERSION;
              res_done   = 1'b1;
            end else if (dim_bad) begin
              res_valid  = 1'b1;
              res_status = ST_DIMS;
              res_done   = 1'b1;
            end else if (off_bad) begin
              res_valid  = 1'b1;
              res_status = ST_OFFSET;
              res_done   = 1'b1;
            end else if (in_last_byte) begin
              res_valid  = 1'b1;
              res_status = ST_TRUNC;
              res_done   = 1'b1;
            end else begin
              pos_nxt = HdrSizeW;
              col_nxt = '0;
              row_nxt = '0;
            end
          end
        end
        PH_DATA: begin
          if (in_gap) begin
            if (in_last_byte) begin
              res_valid  = 1'b1;
              res_status = ST_TRUNC;
              res_done   = 1'b1;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end else begin
            // position stops at the offset; pixels are tracked by column/row
            res_valid = 1'b1;
            res_pix   = 1'b1;
            if (final_px) begin
              res_done = 1'b1;
            end else if (in_last_byte) begin
              res_status = ST_TRUNC;
              res_done   = 1'b1;
            end else if (col_wrap) begin
              col_nxt = '0;
              row_nxt = row_inc[CoordW-1:0];
            end else begin
              col_nxt = col_inc[CoordW-1:0];
            end
          end
        end
        PH_IDLE: res_valid = 1'b0;
        default: res_valid = 1'b0;
      endcase

      if (in_last_byte) begin
        pos_nxt      = '0;
        col_nxt      = '0;
        row_nxt      = '0;
        pal_idx_nxt  = '0;
        pal_comp_nxt = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Palette RAMs: one per color component, indexed by palette entry
  // ---------------------------------------------------------------------------
  itsd_ram #(.WIDTH(8), .DEPTH(PalEntries)) u_pal_red (
    .clk   (clk),
    .we    (pal_we && (pal_comp_r == 2'd0)),
    .waddr (pal_idx_r),
    .wdata (in_data_byte),
    .re    (accept && res_pix),
    .raddr (in_data_byte),
    .rdata (ram_r)
  );

  itsd_ram #(.WIDTH(8), .DEPTH(PalEntries)) u_pal_green (
    .clk   (clk),
    .we    (pal_we && (pal_comp_r == 2'd1)),
    .waddr (pal_idx_r),
    .wdata (in_data_byte),
    .re    (accept && res_pix),
    .raddr (in_data_byte),
    .rdata (ram_g)
  );

  itsd_ram #(.WIDTH(8), .DEPTH(PalEntries)) u_pal_blue (
    .clk   (clk),
    .we    (pal_we && (pal_comp_r == 2'd2)),
    .waddr (pal_idx_r),
    .wdata (in_data_byte),
    .re    (accept && res_pix),
    .raddr (in_data_byte),
    .rdata (ram_b)
  );

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      mip_r       <= '0;
      pos_r       <= '0;
      version_r   <= '0;
      width_r     <= '0;
      height_r    <= '0;
      offset_r    <= '0;
      col_r       <= '0;
      row_r       <= '0;
      pal_idx_r   <= '0;
      pal_comp_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      version_r  <= version_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      offset_r   <= offset_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pal_idx_r  <= pal_idx_nxt;
      pal_comp_r <= pal_comp_nxt;
      if (cfg_valid && cfg_ready) begin
        mip_r <= cfg_level;
      end
      if (in_ready) begin
        s1_valid_r <= accept && res_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r    <= res_pix;
      s1_clear_r  <= (in_data_byte == ClearIdx);
      s1_x_r      <= col_r;
      s1_y_r      <= row_r;
      s1_status_r <= res_status;
      s1_done_r   <= res_done;
    end
    if (advance && s1_valid_r) begin
      out_pix_r    <= s1_pix_r;
      out_red_r    <= s1_pix_r ? ram_r : 8'd0;
      out_green_r  <= s1_pix_r ? ram_g : 8'd0;
      out_blue_r   <= s1_pix_r ? ram_b : 8'd0;
      out_alpha_r  <= (s1_pix_r && !s1_clear_r) ? 8'hFF : 8'd0;
      out_x_r      <= s1_pix_r ? s1_x_r : '0;
      out_y_r      <= s1_pix_r ? s1_y_r : '0;
      out_status_r <= s1_status_r;
      out_done_r   <= s1_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_alpha      = out_alpha_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_has_pixel  = out_pix_r;
  assign out_status     = out_status_r;
  assign out_image_done = out_done_r;

`ifndef SYNTHESIS
  // a byte taken after the image ended never produces a result
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (phase_r == PH_IDLE)) |=> !s1_valid_r)
    else $error("result from a byte after end of image");

  // any error report finishes the image
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> out_image_done)
    else $error("error status without image_done");

  // a pixel carries only ok or truncated status
  a_pix_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_pixel) |-> ((out_status == ST_OK) || (out_status == ST_TRUNC)))
    else $error("pixel with header error status");

  // input only stalls while the pending stage is full
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty pending stage");
`endif

endmodule

`default_nettype wire

// ===== design/itsd_ram.sv =====
`default_nettype none

module itsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import itsd_pkg::*;

  localparam int unsigned MaxDim      = 16384;
  localparam int unsigned DrainCycles = 8;     // output pipe is two deep, plus margin
  localparam int unsigned QuietLimit  = 2000;  // cycles with no transaction at all

  // One result transaction as seen on the out_ channel
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              has_pixel;
    status_t           status;
    logic              done;
  } px_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [MipW-1:0]   cfg_level = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_data_byte = '0;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic [7:0]        out_alpha;
  logic [CoordW-1:0] out_pixel_x;
  logic [CoordW-1:0] out_pixel_y;
  logic              out_has_pixel;
  logic [2:0]        out_status;
  logic              out_image_done;

  indexed_texture_stream_decoder #(
    .MAX_DIM(MaxDim)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_level     (cfg_level),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_has_pixel (out_has_pixel),
    .out_status    (out_status),
    .out_image_done(out_image_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder state mirror: header words of the selected mip, palette, raster
  // counters and the parse phase. Updated once per accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [MipW-1:0] cur_mip = '0;
  phase_t          dec_phase = PH_HEADER;
  logic [32:0]     dec_pos = '0;
  logic [31:0]     hdr_version = '0;
  logic [31:0]     hdr_width = '0;
  logic [31:0]     hdr_height = '0;
  logic [31:0]     hdr_offset = '0;
  logic [7:0]      pal_mem [PalBytes];
  int unsigned     col_cnt = 0;
  int unsigned     row_cnt = 0;

  px_result_t      expected_px [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned results_predicted = 0;
  int unsigned results_seen = 0;
  int unsigned level_writes = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Work out what one accepted byte produces; queue the result, if any.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    px_result_t  r;
    logic        has_res;
    logic        final_px;
    int unsigned p;
    int unsigned lv;
    int unsigned pi;
    r = '0;
    r.status = ST_OK;
    has_res = 1'b0;
    lv = 4 * cur_mip;
    pi = 3 * int'(b);
    case (dec_phase)
      PH_HEADER: begin
        p = dec_pos[31:0];
        // header capture uses the mip level in force as each byte arrives
        if (p < 4) hdr_version[8*p +: 8] = b;
        if (p >= WidthBase + lv && p < WidthBase + lv + 4)
          hdr_width[8*(p - WidthBase - lv) +: 8] = b;
        if (p >= HeightBase + lv && p < HeightBase + lv + 4)
          hdr_height[8*(p - HeightBase - lv) +: 8] = b;
        if (p >= OffsetBase + lv && p < OffsetBase + lv + 4)
          hdr_offset[8*(p - OffsetBase - lv) +: 8] = b;
        if (p >= PalBase && p < PalBase + PalBytes) pal_mem[p - PalBase] = b;
        if (p < HdrSize - 1) begin
          if (last) begin
            r.status = ST_SHORT;
            has_res = 1'b1;
          end else begin
            dec_pos++;
          end
        end else begin
          // checks run in a fixed order: version, dimensions, offset, truncation
          has_res = 1'b1;
          if (hdr_version != VersionOk) r.status = ST_VERSION;
          else if (hdr_width == 0 || hdr_height == 0 ||
                   hdr_width > MaxDim || hdr_height > MaxDim) r.status = ST_DIMS;
          else if (hdr_offset < HdrSize) r.status = ST_OFFSET;
          else if (last) r.status = ST_TRUNC;
          else begin
            has_res = 1'b0;
            dec_phase = PH_DATA;
            dec_pos = 33'(HdrSize);
            col_cnt = 0;
            row_cnt = 0;
          end
        end
        if (has_res) begin
          r.done = 1'b1;
          dec_phase = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (dec_pos < {1'b0, hdr_offset}) begin
          // still in the gap before the pixel data
          if (last) begin
            r.status = ST_TRUNC;
            r.done = 1'b1;
            has_res = 1'b1;
            dec_phase = PH_IDLE;
          end else begin
            dec_pos++;
          end
        end else begin
          final_px = (col_cnt + 1 >= hdr_width) && (row_cnt + 1 >= hdr_height);
          r.red = pal_mem[pi];
          r.green = pal_mem[pi + 1];
          r.blue = pal_mem[pi + 2];
          r.alpha = (b == ClearIndex) ? 8'd0 : 8'd255;
          r.x = col_cnt[CoordW-1:0];
          r.y = row_cnt[CoordW-1:0];
          r.has_pixel = 1'b1;
          has_res = 1'b1;
          if (final_px) begin
            // completion wins over a last flag on the same byte
            r.done = 1'b1;
            dec_phase = PH_IDLE;
          end else if (last) begin
            r.status = ST_TRUNC;
            r.done = 1'b1;
            dec_phase = PH_IDLE;
          end else begin
            col_cnt++;
            if (col_cnt >= hdr_width) begin
              col_cnt = 0;
              row_cnt++;
            end
            dec_pos++;
          end
        end
      end
      default: ;
    endcase
    // any last flag rearms the parser for the next file
    if (last) begin
      dec_phase = PH_HEADER;
      dec_pos = '0;
      col_cnt = 0;
      row_cnt = 0;
    end
    if (has_res) begin
      expected_px.push_back(r);
      results_predicted++;
    end
  endtask

  function automatic string fmt_px(px_result_t r);
    return $sformatf("rgba=%02h%02h%02h%02h x=%0d y=%0d pix=%b st=%0d done=%b",
                     r.red, r.green, r.blue, r.alpha, r.x, r.y, r.has_pixel,
                     r.status, r.done);
  endfunction

  function automatic void report_fault(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    px_result_t got;
    px_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.red = out_red;
      got.green = out_green;
      got.blue = out_blue;
      got.alpha = out_alpha;
      got.x = out_pixel_x;
      got.y = out_pixel_y;
      got.has_pixel = out_has_pixel;
      got.status = status_t'(out_status);
      got.done = out_image_done;
      results_seen++;
      if (expected_px.size() == 0) begin
        report_fault({"unexpected result: ", fmt_px(got)});
      end else begin
        want = expected_px.pop_front();
        if (got !== want)
          report_fault($sformatf("result %0d mismatch: expected %s, got %s",
                                 results_seen, fmt_px(want), fmt_px(got)));
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Valid stays high across back-to-back transactions; it only drops for idles.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  // Stream one file of len bytes. Version and the given mip level's words are
  // placed as requested; the rest of the header (other levels, palette) and all
  // data bytes are random, with the clear index mixed in often.
  task automatic send_file(input logic [31:0] ver, input logic [31:0] w,
                           input logic [31:0] h, input logic [31:0] off,
                           input int unsigned lvl, input int unsigned len);
    int unsigned p;
    int unsigned lb;
    logic [7:0]  b;
    lb = 4 * lvl;
    for (p = 0; p < len; p++) begin
      b = 8'($urandom_range(255));
      if (p < 4) b = ver[8*p +: 8];
      else if (p >= WidthBase + lb && p < WidthBase + lb + 4)
        b = w[8*(p - WidthBase - lb) +: 8];
      else if (p >= HeightBase + lb && p < HeightBase + lb + 4)
        b = h[8*(p - HeightBase - lb) +: 8];
      else if (p >= OffsetBase + lb && p < OffsetBase + lb + 4)
        b = off[8*(p - OffsetBase - lb) +: 8];
      else if (p >= HdrSize && $urandom_range(7) == 0) b = 8'(ClearIndex);
      send_byte(b, p == len - 1);
    end
    files_sent++;
  endtask

  // Bring the block to idle: stop sending, drain, then cover the pipe latency
  // for bytes that produce no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_level(input logic [MipW-1:0] lvl);
    settle();
    cfg_level <= lvl;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mip = lvl;
    level_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_good_images();
    send_file(VersionOk, 2, 2, HdrSize, cur_mip, HdrSize + 4);       // last on final px
    send_file(VersionOk, 3, 2, HdrSize + 5, cur_mip, HdrSize + 14);  // gap and trailer
  endtask

  task automatic test_short_headers();
    send_file(VersionOk, 2, 2, HdrSize, cur_mip, 1);
    send_file(VersionOk, 2, 2, HdrSize, cur_mip, HdrSize - 1);
  endtask

  task automatic test_header_errors();
    send_file(3, 2, 2, HdrSize, cur_mip, HdrSize);                    // with last flag
    // check order: version beats dimensions, dimensions beat offset
    send_file(0, 0, 2, HdrSize, cur_mip, HdrSize + 2);
    send_file(VersionOk, MaxDim + 1, 2, 0, cur_mip, HdrSize + 2);
    send_file(VersionOk, 2, 2, HdrSize - 1, cur_mip, HdrSize + 4);
  endtask

  task automatic test_truncation();
    send_file(VersionOk, 4, 4, HdrSize, cur_mip, HdrSize);              // ends at 1039
    send_file(VersionOk, 4, 4, HdrSize + 8, cur_mip, HdrSize + 3);      // ends in gap
    send_file(VersionOk, MaxDim, 1, HdrSize, cur_mip, HdrSize + 5);     // widest row
  endtask

  task automatic test_mip_select();
    write_level(15);
    send_file(VersionOk, 3, 3, HdrSize + 2, 15, HdrSize + 11);
    write_level(9);
    send_file(VersionOk, 2, 5, HdrSize + 1, 9, HdrSize + 13);
    write_level(0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver stalls heavily
    send_idle_pct = 26;
    recv_idle_pct = 52;
    test_good_images();
    test_short_headers();

    // roles swapped
    send_idle_pct = 52;
    recv_idle_pct = 26;
    test_header_errors();
    test_mip_select();

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_truncation();

    settle();
    if (expected_px.size() != 0)
      report_fault($sformatf("%0d results never arrived", expected_px.size()));

    $display("Decoded %0d files (%0d bytes), %0d of %0d results checked, %0d level writes",
             files_sent, bytes_sent, results_seen, results_predicted, level_writes);
    $display("Covered header errors and their order, short and truncated files, levels 0/9/15; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== indexed_texture_stream_decoder.f =====
design/itsd_pkg.sv
design/itsd_ram.sv
design/indexed_texture_stream_decoder.sv
tb/tb_top.sv
